>>> sv/assert_macros.svh
// Assertion helpers used by the checker of this block.
// Each expects a clock i_clk and an active-low synchronous reset i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// pre in one cycle implies post in the next, ignored while reset is low
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

// pre implies post in the same cycle, ignored while reset is low
`define ASSERT_SAME(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// pre in one cycle implies post in the next, checked through reset as well
`define ASSERT_NEXT_ALWAYS(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> sv/eirp_pkg.sv
`default_nettype none
package eirp_pkg;

    localparam int CFG_W          = 13;
    localparam int CFG_MAX        = (2 ** CFG_W) - 1;
    localparam int CFG_IDX_W      = 2;
    localparam int MARGIN_FIELD_W = 4;
    localparam int OUT_W          = 13;
    localparam int PORT_DATA_W    = 32;
    localparam int QUEUE_DEPTH    = 2;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int DEF_MAX_MARGIN = 8;
    localparam int DEF_ELEM_BITS  = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_MARGIN = 2'd2
    } t_cfg_reg;

    // which image edges an element sits on
    typedef struct packed {
        logic top;
        logic left;
        logic right;
        logic bottom;
    } t_edge;

    localparam int EDGE_W = $bits(t_edge);

    // order in which the writes of one element leave the block
    typedef enum logic [2:0] {
        PH_TOP    = 3'd0,
        PH_LEFT   = 3'd1,
        PH_CENTER = 3'd2,
        PH_RIGHT  = 3'd3,
        PH_BOTTOM = 3'd4
    } t_phase;

    localparam int NUM_PHASES = 5;

endpackage
`default_nettype wire

>>> sv/image_edge_replicate_pad.sv
// Edge-replicating border padder.
// Input channel (i_valid / o_stall, i_element_data): source elements in raster
// order. Output channel (o_valid / i_stall): one write per transaction, giving
// the padded-image column and row, the element value and o_run_last on the final
// write of an element. An element on no edge gives one write; an edge element
// also fills its margin, 1 + 4 * margin writes at most for a one-by-one image.
// Throughput: one write per cycle while not stalled, so one element per cycle
// when no margin is filled; each element's writes come from the single write
// sequencer behind a two-entry queue.
// An accepted element passes through the queue and the sequencer registers to
// the output register before its first write shows.
// Configuration (i_cfg_we, i_cfg_idx, i_cfg_data): width, height, margin; any
// such write restarts the frame at the top-left element. Write only while idle.
// Reset: position back to the frame start, width and height one, margin zero,
// queue and output register empty. When the receiver stalls the output register
// holds; the queue fills and o_stall rises after two more elements.
`default_nettype none
module image_edge_replicate_pad #(
    parameter int MAX_WIDTH  = eirp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = eirp_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_MARGIN = eirp_pkg::DEF_MAX_MARGIN,
    parameter int ELEM_BITS  = eirp_pkg::DEF_ELEM_BITS,
    localparam int WCAP   = (MAX_WIDTH < eirp_pkg::CFG_MAX) ? MAX_WIDTH : eirp_pkg::CFG_MAX,
    localparam int HCAP   = (MAX_HEIGHT < eirp_pkg::CFG_MAX) ? MAX_HEIGHT : eirp_pkg::CFG_MAX,
    localparam int COL_W  = (WCAP > 1) ? $clog2(WCAP) : 1,
    localparam int ROW_W  = (HCAP > 1) ? $clog2(HCAP) : 1,
    localparam int MAR_W  = $clog2(MAX_MARGIN + 1),
    localparam int DATA_W = (ELEM_BITS < eirp_pkg::PORT_DATA_W) ? ELEM_BITS
                                                               : eirp_pkg::PORT_DATA_W,
    localparam int DESC_W = eirp_pkg::EDGE_W + ROW_W + COL_W + DATA_W
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [eirp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [eirp_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [eirp_pkg::PORT_DATA_W-1:0]  i_element_data,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic [eirp_pkg::OUT_W-1:0]             o_out_col,
    output logic [eirp_pkg::OUT_W-1:0]             o_out_row,
    output logic [eirp_pkg::PORT_DATA_W-1:0]       o_out_data,
    output logic                                   o_run_last
);
    import eirp_pkg::*;

    logic              push;
    logic [DESC_W-1:0] push_data;
    logic              pop;
    logic [DESC_W-1:0] q_data;
    logic              q_empty;
    logic              q_full;
    logic [CFG_W-1:0]  width;
    logic [CFG_W-1:0]  height;
    logic [MAR_W-1:0]  margin;

    eirp_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_MARGIN (MAX_MARGIN),
        .ELEM_BITS  (ELEM_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .i_element_data (i_element_data),
        .i_q_full       (q_full),
        .o_stall        (o_stall),
        .o_push         (push),
        .o_push_data    (push_data),
        .o_width        (width),
        .o_height       (height),
        .o_margin       (margin)
    );

    eirp_queue #(
        .WIDTH (DESC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_data  (q_data),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    eirp_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_MARGIN (MAX_MARGIN),
        .ELEM_BITS  (ELEM_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_q_data   (q_data),
        .o_pop      (pop),
        .i_width    (width),
        .i_height   (height),
        .i_margin   (margin),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_out_col  (o_out_col),
        .o_out_row  (o_out_row),
        .o_out_data (o_out_data),
        .o_run_last (o_run_last)
    );

endmodule
`default_nettype wire

>>> sv/eirp_front.sv
`default_nettype none
module eirp_front #(
    parameter int MAX_WIDTH  = eirp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = eirp_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_MARGIN = eirp_pkg::DEF_MAX_MARGIN,
    parameter int ELEM_BITS  = eirp_pkg::DEF_ELEM_BITS,
    localparam int WCAP   = (MAX_WIDTH < eirp_pkg::CFG_MAX) ? MAX_WIDTH : eirp_pkg::CFG_MAX,
    localparam int HCAP   = (MAX_HEIGHT < eirp_pkg::CFG_MAX) ? MAX_HEIGHT : eirp_pkg::CFG_MAX,
    localparam int COL_W  = (WCAP > 1) ? $clog2(WCAP) : 1,
    localparam int ROW_W  = (HCAP > 1) ? $clog2(HCAP) : 1,
    localparam int MAR_W  = $clog2(MAX_MARGIN + 1),
    localparam int DATA_W = (ELEM_BITS < eirp_pkg::PORT_DATA_W) ? ELEM_BITS
                                                               : eirp_pkg::PORT_DATA_W,
    localparam int DESC_W = eirp_pkg::EDGE_W + ROW_W + COL_W + DATA_W
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [eirp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [eirp_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire logic                              i_valid,
    input  wire logic [eirp_pkg::PORT_DATA_W-1:0]  i_element_data,
    input  wire logic                              i_q_full,
    output logic                                   o_stall,
    output logic                                   o_push,
    output logic [DESC_W-1:0]                      o_push_data,
    output logic [eirp_pkg::CFG_W-1:0]             o_width,
    output logic [eirp_pkg::CFG_W-1:0]             o_height,
    output logic [MAR_W-1:0]                       o_margin
);
    import eirp_pkg::*;

    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;
    logic [MAR_W-1:0] r_margin;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    logic [CFG_W-1:0]          n_width;
    logic [CFG_W-1:0]          n_height;
    logic [MAR_W-1:0]          n_margin;
    logic [COL_W-1:0]          n_col;
    logic [ROW_W-1:0]          n_row;
    logic [MARGIN_FIELD_W-1:0] margin_field;
    t_edge                     edges;

    // clamp register values on the way in: zero size means one, large sizes saturate
    always_comb begin
        margin_field = i_cfg_data[MARGIN_FIELD_W-1:0];
        if (i_cfg_data == '0) begin
            n_width  = CFG_W'(1);
            n_height = CFG_W'(1);
        end else begin
            n_width  = (int'(i_cfg_data) > MAX_WIDTH)  ? CFG_W'(MAX_WIDTH)  : i_cfg_data;
            n_height = (int'(i_cfg_data) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : i_cfg_data;
        end
        n_margin = (int'(margin_field) > MAX_MARGIN) ? MAR_W'(MAX_MARGIN)
                                                     : MAR_W'(margin_field);
    end

    always_comb begin
        edges.top    = (r_row == '0);
        edges.left   = (r_col == '0);
        edges.right  = (CFG_W'(r_col) == r_width - CFG_W'(1));
        edges.bottom = (CFG_W'(r_row) == r_height - CFG_W'(1));
        if (edges.right) begin
            n_col = '0;
            n_row = edges.bottom ? '0 : r_row + ROW_W'(1);
        end else begin
            n_col = r_col + COL_W'(1);
            n_row = r_row;
        end
    end

    assign o_stall     = i_q_full;
    assign o_push      = i_valid && !i_q_full;
    assign o_push_data = {edges, r_row, r_col, i_element_data[DATA_W-1:0]};
    assign o_width     = r_width;
    assign o_height    = r_height;
    assign o_margin    = r_margin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_W'(1);
            r_height <= CFG_W'(1);
            r_margin <= '0;
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_WIDTH: begin
                    r_width <= n_width;
                    r_col   <= '0;
                    r_row   <= '0;
                end
                CFG_HEIGHT: begin
                    r_height <= n_height;
                    r_col    <= '0;
                    r_row    <= '0;
                end
                CFG_MARGIN: begin
                    r_margin <= n_margin;
                    r_col    <= '0;
                    r_row    <= '0;
                end
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end else if (o_push) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule
`default_nettype wire

>>> sv/eirp_queue.sv
`default_nettype none
module eirp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = eirp_pkg::QUEUE_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty,
    output logic                  o_full
);
    import eirp_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;

    logic [PTR_W-1:0] n_wp;
    logic [PTR_W-1:0] n_rp;

    assign n_wp    = (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
    assign n_rp    = (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_W'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= n_wp;
            end
            if (i_pop) begin
                r_rp <= n_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> sv/eirp_back.sv
`default_nettype none
module eirp_back #(
    parameter int MAX_WIDTH  = eirp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = eirp_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_MARGIN = eirp_pkg::DEF_MAX_MARGIN,
    parameter int ELEM_BITS  = eirp_pkg::DEF_ELEM_BITS,
    localparam int WCAP   = (MAX_WIDTH < eirp_pkg::CFG_MAX) ? MAX_WIDTH : eirp_pkg::CFG_MAX,
    localparam int HCAP   = (MAX_HEIGHT < eirp_pkg::CFG_MAX) ? MAX_HEIGHT : eirp_pkg::CFG_MAX,
    localparam int COL_W  = (WCAP > 1) ? $clog2(WCAP) : 1,
    localparam int ROW_W  = (HCAP > 1) ? $clog2(HCAP) : 1,
    localparam int MAR_W  = $clog2(MAX_MARGIN + 1),
    localparam int DATA_W = (ELEM_BITS < eirp_pkg::PORT_DATA_W) ? ELEM_BITS
                                                               : eirp_pkg::PORT_DATA_W,
    localparam int DESC_W = eirp_pkg::EDGE_W + ROW_W + COL_W + DATA_W
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_q_empty,
    input  wire logic [DESC_W-1:0]                 i_q_data,
    output logic                                   o_pop,
    input  wire logic [eirp_pkg::CFG_W-1:0]        i_width,
    input  wire logic [eirp_pkg::CFG_W-1:0]        i_height,
    input  wire logic [MAR_W-1:0]                  i_margin,
    input  wire logic                              i_stall,
    output logic                                   o_valid,
    output logic [eirp_pkg::OUT_W-1:0]             o_out_col,
    output logic [eirp_pkg::OUT_W-1:0]             o_out_row,
    output logic [eirp_pkg::PORT_DATA_W-1:0]       o_out_data,
    output logic                                   o_run_last
);
    import eirp_pkg::*;

    // element under expansion
    logic                  r_busy;
    logic [NUM_PHASES-1:0] r_todo;
    logic [MAR_W-1:0]      r_idx;
    logic [COL_W-1:0]      r_col;
    logic [ROW_W-1:0]      r_row;
    logic [DATA_W-1:0]     r_data;

    // output register
    logic                  r_o_valid;
    logic [OUT_W-1:0]      r_o_col;
    logic [OUT_W-1:0]      r_o_row;
    logic [DATA_W-1:0]     r_o_data;
    logic                  r_o_last;

    t_phase                phase;
    t_edge                 q_edges;
    logic                  margin_nz;
    logic                  phase_last;
    logic                  item_last;
    logic                  out_free;
    logic                  emit;
    logic [NUM_PHASES-1:0] todo_rest;
    logic [NUM_PHASES-1:0] todo_load;
    logic [OUT_W-1:0]      m_ext;
    logic [OUT_W-1:0]      i_ext;
    logic [OUT_W-1:0]      col_in;
    logic [OUT_W-1:0]      row_in;
    logic [OUT_W-1:0]      wr_col;
    logic [OUT_W-1:0]      wr_row;

    // first pending phase in write order
    always_comb begin
        phase = PH_CENTER;
        for (int k = NUM_PHASES - 1; k >= 0; k--) begin
            if (r_todo[k]) begin
                phase = t_phase'(3'(k));
            end
        end
    end

    always_comb begin
        margin_nz  = (i_margin != '0);
        phase_last = (phase == PH_CENTER) || (r_idx == i_margin - MAR_W'(1));
        todo_rest  = r_todo & ~(NUM_PHASES'(1) << phase);
        item_last  = phase_last && (todo_rest == '0);
        out_free   = !r_o_valid || !i_stall;
        emit       = r_busy && out_free;
        o_pop      = !i_q_empty && (!r_busy || (emit && item_last));

        q_edges              = t_edge'(i_q_data[DESC_W-1 -: EDGE_W]);
        todo_load            = '0;
        todo_load[PH_TOP]    = q_edges.top && margin_nz;
        todo_load[PH_LEFT]   = q_edges.left && margin_nz;
        todo_load[PH_CENTER] = 1'b1;
        todo_load[PH_RIGHT]  = q_edges.right && margin_nz;
        todo_load[PH_BOTTOM] = q_edges.bottom && margin_nz;
    end

    // padded-image position of the current write, modulo the port width
    always_comb begin
        m_ext  = OUT_W'(i_margin);
        i_ext  = OUT_W'(r_idx);
        col_in = OUT_W'(r_col) + m_ext;
        row_in = OUT_W'(r_row) + m_ext;
        case (phase)
            PH_TOP: begin
                wr_col = col_in;
                wr_row = i_ext;
            end
            PH_LEFT: begin
                wr_col = i_ext;
                wr_row = row_in;
            end
            PH_RIGHT: begin
                wr_col = OUT_W'(i_width) + m_ext + i_ext;
                wr_row = row_in;
            end
            PH_BOTTOM: begin
                wr_col = col_in;
                wr_row = OUT_W'(i_height) + m_ext + i_ext;
            end
            default: begin
                wr_col = col_in;
                wr_row = row_in;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_todo    <= '0;
            r_idx     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_todo <= todo_load;
                r_idx  <= '0;
            end else if (emit) begin
                if (item_last) begin
                    r_busy <= 1'b0;
                end
                if (phase_last) begin
                    r_todo <= todo_rest;
                    r_idx  <= '0;
                end else begin
                    r_idx <= r_idx + MAR_W'(1);
                end
            end
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_q_data[DATA_W-1:0];
            r_col  <= i_q_data[DATA_W +: COL_W];
            r_row  <= i_q_data[DATA_W + COL_W +: ROW_W];
        end
        if (emit) begin
            r_o_col  <= wr_col;
            r_o_row  <= wr_row;
            r_o_data <= r_data;
            r_o_last <= item_last;
        end
    end

    assign o_valid    = r_o_valid;
    assign o_out_col  = r_o_col;
    assign o_out_row  = r_o_row;
    assign o_out_data = PORT_DATA_W'(r_o_data);
    assign o_run_last = r_o_last;

endmodule
`default_nettype wire

>>> sv/eirp_checker.sv
`default_nettype none
`include "assert_macros.svh"
module eirp_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    input  wire logic                              i_in_stall,
    input  wire logic                              i_out_valid,
    input  wire logic                              i_out_stall,
    input  wire logic [eirp_pkg::OUT_W-1:0]        i_out_col,
    input  wire logic [eirp_pkg::OUT_W-1:0]        i_out_row,
    input  wire logic [eirp_pkg::PORT_DATA_W-1:0]  i_out_data,
    input  wire logic                              i_out_last
);
    import eirp_pkg::*;

    `ASSERT_NEXT(a_out_hold, i_out_valid && i_out_stall, i_out_valid, "stalled write dropped")
    `ASSERT_NEXT(a_out_stable, i_out_valid && i_out_stall, $stable({i_out_col, i_out_row, i_out_data, i_out_last}), "stalled write changed")
    `ASSERT_NEXT_ALWAYS(a_reset_empty, !i_rst_n, !i_out_valid && !i_in_stall, "not empty after reset")
    `ASSERT_SAME(a_stall_cause, $rose(i_in_stall), $past(i_in_valid && !i_in_stall), "input stall rose with no transaction taken")

endmodule

bind image_edge_replicate_pad eirp_checker u_eirp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_valid),
    .i_in_stall  (o_stall),
    .i_out_valid (o_valid),
    .i_out_stall (i_stall),
    .i_out_col   (o_out_col),
    .i_out_row   (o_out_row),
    .i_out_data  (o_out_data),
    .i_out_last  (o_run_last)
);
`default_nettype wire
